>>> hw/rtl/srhc_pkg.sv
// Shared types, codes and constants of the stepper ramp and homing controller.
package srhc_pkg;

    localparam int POSITION_BITS_DEF = 32;
    localparam int TIME_BITS_DEF     = 32;

    localparam logic [2:0] MODE_TICK   = 3'd0;
    localparam logic [2:0] MODE_ENABLE = 3'd1;
    localparam logic [2:0] MODE_STOP   = 3'd2;
    localparam logic [2:0] MODE_HOME   = 3'd3;
    localparam logic [2:0] MODE_JOG    = 3'd4;
    localparam logic [2:0] MODE_REL    = 3'd5;
    localparam logic [2:0] MODE_GOTO   = 3'd6;

    localparam logic [2:0] ST_NONE     = 3'd0;
    localparam logic [2:0] ST_REJECTED = 3'd1;
    localparam logic [2:0] ST_HOMED    = 3'd2;
    localparam logic [2:0] ST_ENDSTOP  = 3'd3;
    localparam logic [2:0] ST_GOAL     = 3'd4;
    localparam logic [2:0] ST_BACKOFF  = 3'd5;

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_SEEK    = 2'd1;
    localparam logic [1:0] PH_BACKOFF = 2'd2;

    localparam logic [1:0] REG_START  = 2'd0;
    localparam logic [1:0] REG_CRUISE = 2'd1;
    localparam logic [1:0] REG_DELTA  = 2'd2;

    localparam logic [15:0] START_RST  = 16'd64;
    localparam logic [15:0] CRUISE_RST = 16'd16;
    localparam logic [15:0] DELTA_RST  = 16'd2;
    localparam logic [15:0] BACKOFF_US = 16'd4000;
    localparam logic [15:0] FLOOR_US   = 16'd15;
    localparam logic [16:0] WINDOW_EXTRA = 17'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_STEP,
        S_DONE
    } t_state;

endpackage

>>> hw/rtl/stepper_ramp_homing_controller_unit.sv
// Top level of the stepper ramp and homing controller.
//
//  channel  | direction | handshake          | contents
//  ---------+-----------+--------------------+----------------------------------
//  s        | in        | tvalid / tready    | tuser mode, tdata argument, endstop
//  m        | out       | tvalid / tready    | tdata step result and state
//  cfg      | in        | write enable       | index, 16-bit register value
//
// A command word, or a tick word with no step due, passes S_EXEC and S_DONE to the output
// register; the input is ready again in the cycle after the result is loaded. A tick word
// with a step due also passes S_DIV, where the divider forms the deceleration window, and
// S_STEP. Synchronous active-low reset restores the control, motion and ramp registers; the
// captured word, result fields and output data are not reset. A result waiting on i_m_tready
// does not stop the next word being accepted; the result after it holds until the output register drains.
module stepper_ramp_homing_controller_unit #(
    parameter int POSITION_BITS = srhc_pkg::POSITION_BITS_DEF,
    parameter int TIME_BITS     = srhc_pkg::TIME_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,  // argument[31:0], endstop_level[32], zero pad
    input  logic [2:0]  i_s_tuser,  // mode[2:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [79:0] o_m_tdata,  // step_pulse, step_direction, status[3], is_enabled,
                                    // is_moving, is_homed, position_now[32], goal_now[32],
                                    // direction_now[2], zero pad
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int P = POSITION_BITS;
    localparam int T = TIME_BITS;
    localparam logic [16:0] WINDOW_EXTRA = srhc_pkg::WINDOW_EXTRA;

    srhc_pkg::t_state r_state, n_state;

    logic [15:0] r_start, r_cruise, r_delta;
    logic        r_en, n_en;
    logic        r_mov, n_mov;
    logic        r_homed, n_homed;
    logic [1:0]  r_phase, n_phase;
    logic [P-1:0] r_pos, n_pos;
    logic [P-1:0] r_goal, n_goal;
    logic signed [1:0] r_vel, n_vel;
    logic [T-1:0] r_nst, n_nst;
    logic [15:0] r_int, n_int;
    logic [T-1:0] r_time, n_time;
    logic [2:0]  r_mode;
    logic [31:0] r_arg;
    logic        r_es;
    logic        r_pulse, n_pulse;
    logic        r_dir, n_dir;
    logic [2:0]  r_status, n_status;
    logic        r_ov;
    logic [79:0] r_od;

    logic        div_start;
    logic        div_done;
    logic [15:0] div_quot;
    logic [15:0] window;
    logic        due;
    logic        load_out;

    logic [P-1:0] goal_lo, goal_hi, arg_p, pos_step;
    logic        cont;
    logic [T-1:0] t1, tdiff;
    logic signed [P:0] sd;
    logic [P:0]  span;
    logic [16:0] win17, sum17;
    logic [15:0] ramp;
    logic signed [1:0] lvel;
    logic [P-1:0] lgoal;
    logic        do_launch;

    assign goal_lo = {1'b1, {(P-1){1'b0}}};
    assign goal_hi = ~goal_lo;
    assign cont    = (r_goal == goal_lo) || (r_goal == goal_hi);
    assign arg_p   = r_arg[P-1:0];
    assign t1      = r_time + T'(1);
    assign tdiff   = t1 - r_nst;
    assign window  = (r_start > r_cruise) ? (r_start - r_cruise) : 16'd0;
    assign sd      = $signed({r_goal[P-1], r_goal}) - $signed({r_pos[P-1], r_pos});
    assign span    = sd[P] ? (P+1)'(-sd) : (P+1)'(sd);
    assign win17   = {1'b0, div_quot} + WINDOW_EXTRA;
    assign sum17   = {1'b0, r_int} + {1'b0, r_delta};
    assign pos_step = r_pos + P'(r_vel);
    assign load_out = (r_state == srhc_pkg::S_DONE) && (!r_ov || i_m_tready);

    srhc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (window),
        .i_den   (r_delta),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            srhc_pkg::S_IDLE: if (i_s_tvalid) n_state = srhc_pkg::S_EXEC;
            srhc_pkg::S_EXEC: n_state = due ? srhc_pkg::S_DIV : srhc_pkg::S_DONE;
            srhc_pkg::S_DIV:  if (div_done) n_state = srhc_pkg::S_STEP;
            srhc_pkg::S_STEP: n_state = srhc_pkg::S_DONE;
            srhc_pkg::S_DONE: if (load_out) n_state = srhc_pkg::S_IDLE;
            default:          n_state = srhc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_en = r_en; n_mov = r_mov; n_homed = r_homed; n_phase = r_phase;
        n_pos = r_pos; n_goal = r_goal; n_vel = r_vel; n_nst = r_nst;
        n_int = r_int; n_time = r_time;
        n_pulse = r_pulse; n_dir = r_dir; n_status = r_status;
        due = 1'b0;
        div_start = 1'b0;
        do_launch = 1'b0;
        lvel = 2'sd0;
        lgoal = r_goal;
        ramp = r_int;
        if (r_state == srhc_pkg::S_EXEC) begin
            n_pulse = 1'b0;
            n_dir = 1'b0;
            n_status = srhc_pkg::ST_NONE;
            case (r_mode) inside
                srhc_pkg::MODE_TICK: begin
                    n_time = t1;
                    if (r_mov && r_en) begin
                        if (r_phase == srhc_pkg::PH_BACKOFF && !r_es) begin
                            n_mov = 1'b0; n_vel = 2'sd0; n_nst = '0;
                            n_pos = '0; n_goal = '0; n_homed = 1'b1;
                            n_phase = srhc_pkg::PH_IDLE;
                            n_status = srhc_pkg::ST_HOMED;
                        end else if (r_phase != srhc_pkg::PH_BACKOFF && r_es && r_vel < 0) begin
                            if (r_phase == srhc_pkg::PH_SEEK && r_goal == goal_lo) begin
                                n_vel = 2'sd1; n_goal = goal_hi;
                                n_int = srhc_pkg::BACKOFF_US; n_nst = t1;
                                n_phase = srhc_pkg::PH_BACKOFF;
                                n_status = srhc_pkg::ST_BACKOFF;
                            end else begin
                                n_mov = 1'b0; n_vel = 2'sd0; n_nst = '0;
                                n_goal = r_pos; n_phase = srhc_pkg::PH_IDLE;
                                n_status = srhc_pkg::ST_ENDSTOP;
                            end
                        end else if (!tdiff[T-1]) begin
                            if (r_pos == r_goal) begin
                                n_mov = 1'b0; n_vel = 2'sd0; n_nst = '0;
                                n_status = srhc_pkg::ST_GOAL;
                            end else begin
                                due = 1'b1;
                                div_start = 1'b1;
                            end
                        end
                    end
                end
                srhc_pkg::MODE_ENABLE: begin
                    n_en = (r_arg != 32'd0);
                    if (r_arg == 32'd0) begin
                        n_mov = 1'b0; n_vel = 2'sd0; n_nst = '0;
                        n_goal = r_pos; n_phase = srhc_pkg::PH_IDLE;
                    end
                end
                srhc_pkg::MODE_STOP: begin
                    n_mov = 1'b0; n_vel = 2'sd0; n_nst = '0;
                    n_goal = r_pos; n_phase = srhc_pkg::PH_IDLE;
                end
                srhc_pkg::MODE_HOME, srhc_pkg::MODE_JOG,
                srhc_pkg::MODE_REL, srhc_pkg::MODE_GOTO: begin
                    if (!r_en) begin
                        n_status = srhc_pkg::ST_REJECTED;
                    end else begin
                        do_launch = 1'b1;
                        n_phase = srhc_pkg::PH_IDLE;
                        if (r_mode == srhc_pkg::MODE_HOME) begin
                            n_homed = 1'b0;
                            n_phase = srhc_pkg::PH_SEEK;
                            lvel = -2'sd1;
                            lgoal = goal_lo;
                        end else if (r_mode == srhc_pkg::MODE_JOG) begin
                            lvel = r_arg[31] ? -2'sd1 : 2'sd1;
                            lgoal = r_arg[31] ? goal_lo : goal_hi;
                        end else if (r_mode == srhc_pkg::MODE_REL) begin
                            lvel = (r_arg == 32'd0) ? 2'sd0 : (r_arg[31] ? -2'sd1 : 2'sd1);
                            lgoal = r_pos + P'(r_arg);
                        end else begin
                            lvel = (arg_p == r_pos) ? 2'sd0 :
                                   (($signed(arg_p) > $signed(r_pos)) ? 2'sd1 : -2'sd1);
                            lgoal = arg_p;
                        end
                    end
                end
                default: n_status = srhc_pkg::ST_NONE;
            endcase
            if (do_launch) begin
                n_vel = lvel;
                n_goal = lgoal;
                if (lvel != 2'sd0) begin
                    n_mov = 1'b1; n_int = r_start; n_nst = r_time;
                end else begin
                    n_mov = 1'b0; n_nst = '0;
                end
            end
        end else if (r_state == srhc_pkg::S_STEP) begin
            if (!cont && span <= (P+1)'(win17)) begin
                if (r_int < r_start)
                    ramp = (sum17 > {1'b0, r_start}) ? r_start : sum17[15:0];
            end else if (r_int > r_cruise) begin
                ramp = ((r_int - r_cruise) > r_delta) ? (r_int - r_delta) : r_cruise;
            end
            if (ramp < srhc_pkg::FLOOR_US)
                ramp = srhc_pkg::FLOOR_US;
            n_int = ramp;
            n_pos = pos_step;
            n_pulse = 1'b1;
            n_nst = r_time + T'(ramp);
            n_dir = (r_vel >= 0);
            if (!cont && pos_step == r_goal) begin
                n_mov = 1'b0; n_vel = 2'sd0; n_nst = '0;
                n_status = srhc_pkg::ST_GOAL;
                n_dir = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srhc_pkg::S_IDLE;
            r_start <= srhc_pkg::START_RST;
            r_cruise <= srhc_pkg::CRUISE_RST;
            r_delta <= srhc_pkg::DELTA_RST;
            r_en <= 1'b0; r_mov <= 1'b0; r_homed <= 1'b0;
            r_phase <= srhc_pkg::PH_IDLE;
            r_pos <= '0; r_goal <= '0; r_vel <= 2'sd0;
            r_nst <= '0; r_int <= '0; r_time <= '0;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    srhc_pkg::REG_START:  r_start <= i_cfg_data;
                    srhc_pkg::REG_CRUISE: r_cruise <= i_cfg_data;
                    srhc_pkg::REG_DELTA:  r_delta <= i_cfg_data;
                    default: ;
                endcase
            end
            r_en <= n_en; r_mov <= n_mov; r_homed <= n_homed; r_phase <= n_phase;
            r_pos <= n_pos; r_goal <= n_goal; r_vel <= n_vel;
            r_nst <= n_nst; r_int <= n_int; r_time <= n_time;
            if (load_out)
                r_ov <= 1'b1;
            else if (i_m_tready)
                r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == srhc_pkg::S_IDLE && i_s_tvalid) begin
            r_mode <= i_s_tuser;
            r_arg  <= i_s_tdata[31:0];
            r_es   <= i_s_tdata[32];
        end
        r_pulse <= n_pulse;
        r_dir <= n_dir;
        r_status <= n_status;
        if (load_out)
            r_od <= {6'd0, r_vel, 32'($signed(r_goal)), 32'($signed(r_pos)),
                     r_homed, r_mov, r_en, r_status, r_dir, r_pulse};
    end

    assign o_s_tready = (r_state == srhc_pkg::S_IDLE);
    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_od;

endmodule

>>> hw/rtl/srhc_div.sv
// Restoring 16-bit divider, one quotient bit per cycle; zero divisor returns the dividend.
module srhc_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_num,
    input  logic [15:0] i_den,
    output logic        o_done,
    output logic [15:0] o_quot
);

    logic        r_busy;
    logic        r_done;
    logic [3:0]  r_cnt;
    logic [16:0] r_rem;
    logic [15:0] r_q;
    logic [15:0] r_num;
    logic [15:0] r_den;

    logic [16:0] shifted;
    logic [16:0] n_rem;
    logic        qbit;

    always_comb begin
        shifted = {r_rem[15:0], r_q[15]};
        if (shifted >= {1'b0, r_den}) begin
            n_rem = shifted - {1'b0, r_den};
            qbit  = 1'b1;
        end else begin
            n_rem = shifted;
            qbit  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_q    <= i_num;
                r_num  <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_q   <= {r_q[14:0], qbit};
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = (r_den == 16'd0) ? r_num : r_q;

endmodule

>>> verif/srhc_checker.sv
// Checker for the stepper ramp and homing controller: predicts and compares result words.
module srhc_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [39:0] i_s_tdata,
    input  logic [2:0]  i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [79:0] i_m_tdata,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [1:0]  dir;
        logic [31:0] goal;
        logic [31:0] pos;
        logic        homed;
        logic        moving;
        logic        en;
        logic [2:0]  status;
        logic        sdir;
        logic        pulse;
    } t_motion;

    localparam logic [31:0] GOAL_LO = 32'h8000_0000;
    localparam logic [31:0] GOAL_HI = 32'h7fff_ffff;

    logic [15:0] start_iv, cruise_iv, delta_iv;
    logic        en_q, moving_q, homed_q;
    logic [1:0]  phase_q;
    logic [31:0] pos_q, goal_q, next_due, interval_q, now_us;
    int          vel_q;
    t_motion     motion_q[$];

    assign o_pending = motion_q.size();

    function automatic logic endless_goal();
        return goal_q == GOAL_LO || goal_q == GOAL_HI;
    endfunction

    task automatic halt();
        moving_q = 1'b0;
        vel_q    = 0;
        next_due = '0;
    endtask

    task automatic launch(input int vel, input logic [31:0] goal);
        vel_q  = vel;
        goal_q = goal;
        if (vel != 0) begin
            moving_q   = 1'b1;
            interval_q = 32'(start_iv);
            next_due   = now_us;
        end else begin
            moving_q = 1'b0;
            next_due = '0;
        end
    endtask

    task automatic speed_up();
        if (interval_q > 32'(cruise_iv)) begin
            if (interval_q - 32'(cruise_iv) > 32'(delta_iv))
                interval_q = interval_q - 32'(delta_iv);
            else
                interval_q = 32'(cruise_iv);
        end
    endtask

    task automatic advance_tick(input logic es, output logic [2:0] st, output logic pulse);
        logic [31:0] lag, window, grown;
        longint      span;
        st    = srhc_pkg::ST_NONE;
        pulse = 1'b0;
        now_us = now_us + 32'd1;
        if (!moving_q || !en_q)
            return;
        if (phase_q == srhc_pkg::PH_BACKOFF) begin
            if (!es) begin
                halt();
                pos_q   = '0;
                goal_q  = '0;
                homed_q = 1'b1;
                phase_q = srhc_pkg::PH_IDLE;
                st = srhc_pkg::ST_HOMED;
                return;
            end
        end else if (es && vel_q < 0) begin
            if (phase_q == srhc_pkg::PH_SEEK && goal_q == GOAL_LO) begin
                vel_q      = 1;
                goal_q     = GOAL_HI;
                interval_q = 32'(srhc_pkg::BACKOFF_US);
                next_due   = now_us;
                phase_q    = srhc_pkg::PH_BACKOFF;
                st = srhc_pkg::ST_BACKOFF;
                return;
            end
            halt();
            goal_q  = pos_q;
            phase_q = srhc_pkg::PH_IDLE;
            st = srhc_pkg::ST_ENDSTOP;
            return;
        end
        lag = now_us - next_due;
        if (lag[31])
            return;
        if (pos_q == goal_q) begin
            halt();
            st = srhc_pkg::ST_GOAL;
            return;
        end
        span = longint'($signed(goal_q)) - longint'($signed(pos_q));
        if (span < 0)
            span = -span;
        window = start_iv > cruise_iv ? 32'(start_iv - cruise_iv) : 32'd0;
        window = (delta_iv != 0 ? window / 32'(delta_iv) : window)
                 + 32'(srhc_pkg::WINDOW_EXTRA);
        if (endless_goal()) begin
            speed_up();
        end else if (span <= longint'(window)) begin
            if (interval_q < 32'(start_iv)) begin
                grown = interval_q + 32'(delta_iv);
                interval_q = grown > 32'(start_iv) ? 32'(start_iv) : grown;
            end
        end else begin
            speed_up();
        end
        if (interval_q < 32'(srhc_pkg::FLOOR_US))
            interval_q = 32'(srhc_pkg::FLOOR_US);
        pos_q    = pos_q + 32'(vel_q);
        pulse    = 1'b1;
        next_due = now_us + interval_q;
        if (!endless_goal() && pos_q == goal_q) begin
            halt();
            st = srhc_pkg::ST_GOAL;
        end
    endtask

    task automatic predict_motion(input logic [2:0] mode, input logic [31:0] arg,
                                  input logic es, output t_motion r);
        logic [2:0] st;
        logic       pulse;
        int         sgn;
        st    = srhc_pkg::ST_NONE;
        pulse = 1'b0;
        sgn   = arg[31] ? -1 : 1;
        case (mode) inside
            srhc_pkg::MODE_TICK: begin
                advance_tick(es, st, pulse);
            end
            srhc_pkg::MODE_ENABLE: begin
                en_q = arg != 0;
                if (!en_q) begin
                    halt();
                    goal_q  = pos_q;
                    phase_q = srhc_pkg::PH_IDLE;
                end
            end
            srhc_pkg::MODE_STOP: begin
                halt();
                goal_q  = pos_q;
                phase_q = srhc_pkg::PH_IDLE;
            end
            srhc_pkg::MODE_HOME, srhc_pkg::MODE_JOG,
            srhc_pkg::MODE_REL, srhc_pkg::MODE_GOTO: begin
                if (!en_q) begin
                    st = srhc_pkg::ST_REJECTED;
                end else if (mode == srhc_pkg::MODE_HOME) begin
                    homed_q = 1'b0;
                    phase_q = srhc_pkg::PH_SEEK;
                    launch(-1, GOAL_LO);
                end else if (mode == srhc_pkg::MODE_JOG) begin
                    phase_q = srhc_pkg::PH_IDLE;
                    launch(sgn, arg[31] ? GOAL_LO : GOAL_HI);
                end else if (mode == srhc_pkg::MODE_REL) begin
                    phase_q = srhc_pkg::PH_IDLE;
                    launch(arg == 0 ? 0 : sgn, pos_q + arg);
                end else begin
                    phase_q = srhc_pkg::PH_IDLE;
                    launch($signed(arg) == $signed(pos_q) ? 0 :
                           ($signed(arg) > $signed(pos_q) ? 1 : -1), arg);
                end
            end
            default: ;
        endcase
        r.pulse  = pulse;
        r.sdir   = pulse && (vel_q >= 0 || st == srhc_pkg::ST_GOAL);
        r.status = st;
        r.en     = en_q;
        r.moving = moving_q;
        r.homed  = homed_q;
        r.pos    = pos_q;
        r.goal   = goal_q;
        r.dir    = 2'(vel_q);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_motion want, got;
        if (!i_rst_n) begin
            start_iv   = srhc_pkg::START_RST;
            cruise_iv  = srhc_pkg::CRUISE_RST;
            delta_iv   = srhc_pkg::DELTA_RST;
            en_q       = 1'b0;
            moving_q   = 1'b0;
            homed_q    = 1'b0;
            phase_q    = srhc_pkg::PH_IDLE;
            pos_q      = '0;
            goal_q     = '0;
            next_due   = '0;
            interval_q = '0;
            now_us     = '0;
            vel_q      = 0;
            motion_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    srhc_pkg::REG_START:  start_iv  = i_cfg_data;
                    srhc_pkg::REG_CRUISE: cruise_iv = i_cfg_data;
                    srhc_pkg::REG_DELTA:  delta_iv  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got = t_motion'(i_m_tdata[$bits(t_motion)-1:0]);
                if (motion_q.size() == 0) begin
                    $display("%0t: unexpected word, expected none, got %h", $time, i_m_tdata);
                    o_fail_count++;
                end else begin
                    want = motion_q.pop_front();
                    check_field("step_pulse", 32'(want.pulse), 32'(got.pulse));
                    check_field("step_direction", 32'(want.sdir), 32'(got.sdir));
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("is_enabled", 32'(want.en), 32'(got.en));
                    check_field("is_moving", 32'(want.moving), 32'(got.moving));
                    check_field("is_homed", 32'(want.homed), 32'(got.homed));
                    check_field("position_now", want.pos, got.pos);
                    check_field("goal_now", want.goal, got.goal);
                    check_field("direction_now", 32'(want.dir), 32'(got.dir));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_motion(i_s_tuser, i_s_tdata[31:0], i_s_tdata[32], want);
                motion_q.push_back(want);
            end
        end
    end

endmodule

>>> verif/testbench.sv
// Testbench top: clock, reset, stimulus, receiver stalls and the verdict.
module testbench;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [39:0] i_s_tdata = '0;
    logic [2:0]  i_s_tuser = srhc_pkg::MODE_TICK;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [79:0] o_m_tdata;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = srhc_pkg::REG_START;
    logic [15:0] i_cfg_data = '0;
    int          fail_count, pending;
    int          burst_left = 0;
    int          words_sent = 0;
    int          quiet_cycles = 0;
    int          rx_cycle = 0;
    logic        endstop_hit = 1'b0;

    always #5 i_clk = ~i_clk;

    stepper_ramp_homing_controller_unit u_dut (.*);

    srhc_checker u_checker (
        .i_clk, .i_rst_n, .i_s_tvalid, .i_s_tready(o_s_tready), .i_s_tdata, .i_s_tuser,
        .i_m_tvalid(o_m_tvalid), .i_m_tready, .i_m_tdata(o_m_tdata),
        .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // hold off for a long stretch once per period, otherwise stall at random or not at all
    always @(negedge i_clk) begin
        rx_cycle <= (rx_cycle + 1) % 3000;
        if (rx_cycle >= 2000 && rx_cycle < 2300)
            i_m_tready <= 1'b0;
        else if (rx_cycle < 600)
            i_m_tready <= 1'b1;
        else
            i_m_tready <= $urandom_range(0, 3) != 0;
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send(input logic [2:0] mode, input logic [31:0] arg, input logic es);
        if (burst_left == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= mode;
        i_s_tdata  <= {7'd0, es, arg};
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        @(negedge i_clk);
        words_sent++;
    endtask

    task automatic ticks(input int n, input int es_odds);
        repeat (n) begin
            if ($urandom_range(0, es_odds) == 0)
                endstop_hit = ~endstop_hit;
            send(srhc_pkg::MODE_TICK, $urandom, endstop_hit);
        end
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0)
            @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    task automatic set_ramp(input logic [15:0] start_v, input logic [15:0] cruise_v,
                            input logic [15:0] delta_v);
        i_cfg_we <= 1'b1;
        i_cfg_index <= srhc_pkg::REG_START;
        i_cfg_data <= start_v;
        @(negedge i_clk);
        i_cfg_index <= srhc_pkg::REG_CRUISE;
        i_cfg_data <= cruise_v;
        @(negedge i_clk);
        i_cfg_index <= srhc_pkg::REG_DELTA;
        i_cfg_data <= delta_v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_sequence();
        logic [31:0] arg;
        if ($urandom_range(0, 4) != 0)
            send(srhc_pkg::MODE_ENABLE, $urandom_range(1, 7), 1'b0);
        endstop_hit = 1'b0;
        case ($urandom_range(0, 9))
            0: send(srhc_pkg::MODE_ENABLE, $urandom_range(0, 2) == 0 ? 32'd0 : $urandom,
                    1'b0);
            1: send(srhc_pkg::MODE_STOP, $urandom, endstop_hit);
            2: begin
                send(srhc_pkg::MODE_HOME, $urandom, 1'b0);
                ticks($urandom_range(5, 40), 1000);
                endstop_hit = 1'b1;
                ticks($urandom_range(1, 4), 1000);
                endstop_hit = 1'b0;
                ticks($urandom_range(1, 10), 1000);
            end
            3: begin
                send(srhc_pkg::MODE_JOG, $urandom, 1'b0);
                ticks($urandom_range(10, 60), 40);
            end
            4, 5: begin
                arg = $urandom_range(0, 7) == 0 ? $urandom : 32'($urandom_range(0, 80) - 40);
                send(srhc_pkg::MODE_REL, arg, 1'b0);
                ticks($urandom_range(10, 80), 200);
            end
            6, 7: begin
                arg = $urandom_range(0, 7) == 0 ? $urandom : 32'($urandom_range(0, 120) - 60);
                send(srhc_pkg::MODE_GOTO, arg, 1'b0);
                ticks($urandom_range(10, 80), 200);
            end
            8: send(3'($urandom_range(0, 6)), $urandom, 1'($urandom));
            default: ticks($urandom_range(5, 30), 10);
        endcase
    endtask

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send(srhc_pkg::MODE_HOME, 32'd1, 1'b0);
        send(srhc_pkg::MODE_JOG, 32'hffff_ffff, 1'b0);
        send(srhc_pkg::MODE_ENABLE, 32'h8000_0000, 1'b0);
        send(srhc_pkg::MODE_JOG, 32'h8000_0000, 1'b0);
        send(srhc_pkg::MODE_TICK, 32'd0, 1'b0);
        send(srhc_pkg::MODE_TICK, 32'hffff_ffff, 1'b1);
        send(srhc_pkg::MODE_JOG, 32'h7fff_ffff, 1'b1);
        send(srhc_pkg::MODE_TICK, 32'd0, 1'b1);
        send(srhc_pkg::MODE_STOP, 32'd0, 1'b0);
        send(srhc_pkg::MODE_REL, 32'd0, 1'b0);
        send(srhc_pkg::MODE_GOTO, 32'd1, 1'b0);
        send(srhc_pkg::MODE_TICK, 32'd0, 1'b0);
        send(srhc_pkg::MODE_REL, 32'd1, 1'b0);
        send(srhc_pkg::MODE_TICK, 32'd0, 1'b0);
        send(srhc_pkg::MODE_GOTO, 32'h7fff_ffff, 1'b0);
        send(srhc_pkg::MODE_TICK, 32'd0, 1'b0);
        send(srhc_pkg::MODE_HOME, 32'd0, 1'b0);
        send(srhc_pkg::MODE_TICK, 32'd0, 1'b0);
        send(srhc_pkg::MODE_TICK, 32'd0, 1'b1);
        send(srhc_pkg::MODE_TICK, 32'd0, 1'b1);
        send(srhc_pkg::MODE_TICK, 32'd0, 1'b0);
        send(srhc_pkg::MODE_ENABLE, 32'd0, 1'b0);
        send(srhc_pkg::MODE_GOTO, 32'h8000_0000, 1'b0);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_ramp(16'd1, 16'd1, 16'd1);
                1: set_ramp(16'd30, 16'd15, 16'd3);
                2: set_ramp(16'hffff, 16'hffff, 16'hffff);
                3: set_ramp(16'd16, 16'd40, 16'd1);
                4: set_ramp(16'd500, 16'd20, 16'hffff);
                default: set_ramp(srhc_pkg::START_RST, srhc_pkg::CRUISE_RST,
                                  srhc_pkg::DELTA_RST);
            endcase
            while (words_sent < 25 + (ph + 1) * 165)
                random_sequence();
            drain();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> stepper_ramp_homing_controller_unit.f
hw/rtl/srhc_pkg.sv
hw/rtl/srhc_div.sv
hw/rtl/stepper_ramp_homing_controller_unit.sv
verif/srhc_checker.sv
verif/testbench.sv
